// ===== rtl/core/qmr_pkg.sv =====
// qmr_pkg: shared types, widths and constants of the quaternion multiply/rotate unit.
// Used by qmr_hamilton and quaternion_multiply_rotate_unit_top; depends on nothing.
package qmr_pkg;

  localparam int FRAC_BITS = 16;             // Q16.16 fraction bits
  localparam int Q_W       = 32;             // component width
  localparam int OP_W      = Q_W + 1;        // operand width, holds the exact conjugate
  localparam int PROD_W    = 2 * OP_W;       // full product width
  localparam int RND_W     = PROD_W - FRAC_BITS;
  localparam int SUM_W     = RND_W + 2;      // four rounded terms
  localparam int N_COMP    = 4;

  // Component order inside every quaternion vector
  localparam int IDX_X = 0;
  localparam int IDX_Y = 1;
  localparam int IDX_Z = 2;
  localparam int IDX_W = 3;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Sideband that rides along both product passes
  typedef struct packed {
    logic             mode;   // 0 = product, 1 = rotate
    op_t [N_COMP-1:0] c;      // conjugate of A, exact at OP_W bits
    q_t  [N_COMP-1:0] t;      // first-pass result
    logic             ovf;    // saturation seen in the first pass
  } side_t;

endpackage

// ===== rtl/core/qmr_hamilton.sv =====
// qmr_hamilton: three-stage pipelined Hamilton product with rounding and saturation.
// Stages: products, round to nearest, signed sum and saturate. Depends on qmr_pkg.
module qmr_hamilton (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  qmr_pkg::op_t [qmr_pkg::N_COMP-1:0]         p,
  input  qmr_pkg::op_t [qmr_pkg::N_COMP-1:0]         q,
  input  qmr_pkg::side_t                             side_in,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output qmr_pkg::q_t  [qmr_pkg::N_COMP-1:0]         r,
  output logic [qmr_pkg::N_COMP-1:0]                 sat,
  output qmr_pkg::side_t                             side_out
);

  localparam qmr_pkg::prod_t PROD_HALF = qmr_pkg::prod_t'(1) << (qmr_pkg::FRAC_BITS - 1);
  localparam qmr_pkg::sum_t  SAT_MAX   =
    {{(qmr_pkg::SUM_W - qmr_pkg::Q_W + 1){1'b0}}, {(qmr_pkg::Q_W - 1){1'b1}}};
  localparam qmr_pkg::sum_t  SAT_MIN   =
    {{(qmr_pkg::SUM_W - qmr_pkg::Q_W + 1){1'b1}}, {(qmr_pkg::Q_W - 1){1'b0}}};

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  qmr_pkg::prod_t m_r   [qmr_pkg::N_COMP][qmr_pkg::N_COMP];
  qmr_pkg::rnd_t  rnd_r [qmr_pkg::N_COMP][qmr_pkg::N_COMP];
  qmr_pkg::rnd_t  rnd_nxt [qmr_pkg::N_COMP][qmr_pkg::N_COMP];
  qmr_pkg::prod_t biased [qmr_pkg::N_COMP][qmr_pkg::N_COMP];
  qmr_pkg::sum_t  sum    [qmr_pkg::N_COMP];
  qmr_pkg::q_t  [qmr_pkg::N_COMP-1:0] r_r, r_nxt;
  logic [qmr_pkg::N_COMP-1:0] sat_r, sat_nxt;
  qmr_pkg::side_t s1_r, s2_r, s3_r;

  // Stage enables: a stage loads when empty or when the next one moves
  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Round: add half an LSB, then floor-shift by dropping fraction bits
  always_comb begin
    for (int i = 0; i < qmr_pkg::N_COMP; i++) begin
      for (int j = 0; j < qmr_pkg::N_COMP; j++) begin
        biased[i][j]  = m_r[i][j] + PROD_HALF;
        rnd_nxt[i][j] = biased[i][j][qmr_pkg::PROD_W-1:qmr_pkg::FRAC_BITS];
      end
    end
  end

  // Signed sums of the Hamilton product, then clamp to 32 bits
  always_comb begin
    sum[qmr_pkg::IDX_X] =
        qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_W][qmr_pkg::IDX_X])
      + qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_X][qmr_pkg::IDX_W])
      + qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_Y][qmr_pkg::IDX_Z])
      - qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_Z][qmr_pkg::IDX_Y]);
    sum[qmr_pkg::IDX_Y] =
        qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_W][qmr_pkg::IDX_Y])
      - qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_X][qmr_pkg::IDX_Z])
      + qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_Y][qmr_pkg::IDX_W])
      + qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_Z][qmr_pkg::IDX_X]);
    sum[qmr_pkg::IDX_Z] =
        qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_W][qmr_pkg::IDX_Z])
      + qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_X][qmr_pkg::IDX_Y])
      - qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_Y][qmr_pkg::IDX_X])
      + qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_Z][qmr_pkg::IDX_W]);
    sum[qmr_pkg::IDX_W] =
        qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_W][qmr_pkg::IDX_W])
      - qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_X][qmr_pkg::IDX_X])
      - qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_Y][qmr_pkg::IDX_Y])
      - qmr_pkg::sum_t'(rnd_r[qmr_pkg::IDX_Z][qmr_pkg::IDX_Z]);
    for (int k = 0; k < qmr_pkg::N_COMP; k++) begin
      if (sum[k] > SAT_MAX) begin
        r_nxt[k]   = SAT_MAX[qmr_pkg::Q_W-1:0];
        sat_nxt[k] = 1'b1;
      end else if (sum[k] < SAT_MIN) begin
        r_nxt[k]   = SAT_MIN[qmr_pkg::Q_W-1:0];
        sat_nxt[k] = 1'b1;
      end else begin
        r_nxt[k]   = sum[k][qmr_pkg::Q_W-1:0];
        sat_nxt[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < qmr_pkg::N_COMP; i++) begin
        for (int j = 0; j < qmr_pkg::N_COMP; j++) begin
          m_r[i][j] <= $signed(p[i]) * $signed(q[j]);
        end
      end
      s1_r <= side_in;
    end
    if (en2) begin
      rnd_r <= rnd_nxt;
      s2_r  <= s1_r;
    end
    if (en3) begin
      r_r   <= r_nxt;
      sat_r <= sat_nxt;
      s3_r  <= s2_r;
    end
  end

  assign out_valid = v3_r;
  assign r         = r_r;
  assign sat       = sat_r;
  assign side_out  = s3_r;

endmodule

// ===== rtl/core/quaternion_multiply_rotate_unit_top.sv =====
// quaternion_multiply_rotate_unit_top: streaming Q16.16 quaternion product and rotation.
// Instantiates qmr_hamilton twice; depends on qmr_pkg.
//
// Usage:
//   Input transfer: in_tdata carries operands A and B, in_tuser the mode
//   (0 = Hamilton product A*B, 1 = rotate vector B.xyz by A, giving
//   A*(B,0)*conj(A) with w = 0; B.w is ignored in that mode).
//   Output transfer: out_tdata carries the result, out_tuser the overflow
//   flag, set when any computed component saturated to 32 bits.
//   Every product is rounded to nearest (ties toward plus infinity) into
//   Q16.16; the four terms of a component are summed exactly, then clamped.
// Pipeline and throughput:
//   An input transfer passes through two 3-stage product passes
//   (multiply, round, sum and clamp) and then the output register. Product mode
//   items also go through the second pass and keep the first-pass result.
//   One item per cycle sustained while out_tready is high; no state between items.
// Reset and stall:
//   rst_n (synchronous, active low) empties every stage. When the receiver
//   holds out_tready low, each stage holds only while the one after it is
//   full, so bubbles close up and in_tready stays high until the whole chain
//   is occupied. Nothing is dropped or repeated.
module quaternion_multiply_rotate_unit_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // from bit 0 up: a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (32 bits each)
  input  logic [255:0] in_tdata,
  // bit 0: mode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // from bit 0 up: r_x, r_y, r_z, r_w (32 bits each)
  output logic [127:0] out_tdata,
  // bit 0: overflow
  output logic         out_tuser
);

  localparam int NC = qmr_pkg::N_COMP;
  localparam int QW = qmr_pkg::Q_W;

  qmr_pkg::q_t  a_in [NC];
  qmr_pkg::q_t  b_in [NC];
  qmr_pkg::op_t [NC-1:0] p1, q1, p2;
  qmr_pkg::side_t side1, side1_out, side2, side2_out;
  qmr_pkg::q_t  [NC-1:0] r1, r2;
  logic [NC-1:0] sat1, sat2;
  logic h1_out_valid, h1_out_ready, h2_out_valid, h2_out_ready;
  logic out_en;

  logic            out_tvalid_r;
  logic [127:0]    out_tdata_r, out_tdata_nxt;
  logic            out_tuser_r, out_tuser_nxt;

  // Unpack operands; build the exact conjugate of A alongside the first pass
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      a_in[i] = qmr_pkg::q_t'(in_tdata[i*QW +: QW]);
      b_in[i] = qmr_pkg::q_t'(in_tdata[(NC+i)*QW +: QW]);
      p1[i]   = qmr_pkg::op_t'(a_in[i]);
      q1[i]   = qmr_pkg::op_t'(b_in[i]);
    end
    // Rotate mode treats B as a pure vector
    if (in_tuser) q1[qmr_pkg::IDX_W] = '0;

    side1.mode                = in_tuser;
    side1.c[qmr_pkg::IDX_X]   = -qmr_pkg::op_t'(a_in[qmr_pkg::IDX_X]);
    side1.c[qmr_pkg::IDX_Y]   = -qmr_pkg::op_t'(a_in[qmr_pkg::IDX_Y]);
    side1.c[qmr_pkg::IDX_Z]   = -qmr_pkg::op_t'(a_in[qmr_pkg::IDX_Z]);
    side1.c[qmr_pkg::IDX_W]   = qmr_pkg::op_t'(a_in[qmr_pkg::IDX_W]);
    side1.t                   = '0;
    side1.ovf                 = 1'b0;
  end

  // First pass: A*B, or A*(B.xyz, 0) when rotating
  qmr_hamilton u_pass1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .p         (p1),
    .q         (q1),
    .side_in   (side1),
    .out_valid (h1_out_valid),
    .out_ready (h1_out_ready),
    .r         (r1),
    .sat       (sat1),
    .side_out  (side1_out)
  );

  // Hand the first result to the second pass and keep it in the sideband
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      p2[i] = qmr_pkg::op_t'(r1[i]);
    end
    side2      = side1_out;
    side2.t    = r1;
    side2.ovf  = |sat1;
  end

  // Second pass: T*conj(A); its result is used in rotate mode only
  qmr_hamilton u_pass2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (h1_out_valid),
    .in_ready  (h1_out_ready),
    .p         (p2),
    .q         (side1_out.c),
    .side_in   (side2),
    .out_valid (h2_out_valid),
    .out_ready (h2_out_ready),
    .r         (r2),
    .sat       (sat2),
    .side_out  (side2_out)
  );

  // Output register: advance when empty or when the receiver takes the transfer
  assign out_en       = !out_tvalid_r || out_tready;
  assign h2_out_ready = out_en;

  always_comb begin
    if (side2_out.mode) begin
      // Rotate: vector part of the second pass, scalar forced to zero
      out_tdata_nxt = {{QW{1'b0}}, r2[qmr_pkg::IDX_Z], r2[qmr_pkg::IDX_Y], r2[qmr_pkg::IDX_X]};
      out_tuser_nxt = side2_out.ovf | sat2[qmr_pkg::IDX_X] | sat2[qmr_pkg::IDX_Y]
                    | sat2[qmr_pkg::IDX_Z];
    end else begin
      out_tdata_nxt = side2_out.t;
      out_tuser_nxt = side2_out.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_en) begin
      out_tvalid_r <= h2_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef ASSERT_OFF
  // An empty output register lets every stage advance, so input must be open
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low while output register empty");

  // A transfer out of the second pass must land in the output register
  a_pass2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    h2_out_valid && h2_out_ready |=> out_tvalid)
    else $error("second-pass result lost before output register");

  // Reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");
`endif

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for quaternion_multiply_rotate_unit_top (product and rotate).
// Drives operand transfers and checks every result against table values or an in-bench fixed-point predictor.
// Depends on qmr_pkg for the component types and widths.
module testbench;
  import qmr_pkg::*;

  // Operation codes carried on in_tuser
  localparam logic MODE_PRODUCT = 1'b0;
  localparam logic MODE_ROTATE  = 1'b1;

  // Handy Q16.16 values
  localparam q_t Q_ONE  = 32'sh0001_0000;
  localparam q_t Q_HALF = 32'sh0000_8000;
  localparam q_t Q_LSB  = 32'sh0000_0001;
  localparam q_t Q_MAX  = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN  = 32'sh8000_0000;

  localparam int N_DIRECTED   = 21;
  localparam int RANDOM_ITEMS = 830;
  localparam int IDLE_LIMIT   = 1000;   // cycles without any transfer
  localparam int DRAIN_CYCLES = 20;     // pipeline is 7 deep, allow margin
  localparam int MAX_REPORTS  = 10;

  // Operand word, ax in the lowest bits of in_tdata
  typedef struct packed {
    q_t bw, bz, by, bx, aw, az, ay, ax;
  } opnd_t;

  // Result word, x in the lowest bits of out_tdata
  typedef struct packed {
    q_t w, z, y, x;
  } vec_t;

  typedef struct packed {
    logic ovf;
    q_t   w, z, y, x;
  } quat_res_t;

  // One directed stimulus row; the result fields count only where known is set
  typedef struct packed {
    logic mode;
    q_t   ax, ay, az, aw, bx, by, bz, bw;
    logic known;
    q_t   rx, ry, rz, rw;
    logic ovf;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // all zero operands
    '{MODE_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0, 1'b0},
    // identity times identity
    '{MODE_PRODUCT, 0, 0, 0, Q_ONE, 0, 0, 0, Q_ONE, 1'b1, 0, 0, 0, Q_ONE, 1'b0},
    // i*j = k, j*i = -k, i*i = -1
    '{MODE_PRODUCT, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0, 1'b1, 0, 0, Q_ONE, 0, 1'b0},
    '{MODE_PRODUCT, 0, Q_ONE, 0, 0, Q_ONE, 0, 0, 0, 1'b1, 0, 0, -Q_ONE, 0, 1'b0},
    '{MODE_PRODUCT, Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0, 1'b1, 0, 0, 0, -Q_ONE, 1'b0},
    // rounding ties go toward plus infinity
    '{MODE_PRODUCT, 0, 0, 0, Q_LSB, 0, 0, 0, Q_HALF, 1'b1, 0, 0, 0, Q_LSB, 1'b0},
    '{MODE_PRODUCT, 0, 0, 0, -Q_LSB, 0, 0, 0, Q_HALF, 1'b1, 0, 0, 0, 0, 1'b0},
    // saturation high, low, and min times min
    '{MODE_PRODUCT, 0, 0, 0, Q_MAX, 0, 0, 0, Q_MAX, 1'b1, 0, 0, 0, Q_MAX, 1'b1},
    '{MODE_PRODUCT, 0, 0, 0, Q_MIN, 0, 0, 0, Q_MAX, 1'b1, 0, 0, 0, Q_MIN, 1'b1},
    '{MODE_PRODUCT, 0, 0, 0, Q_MIN, 0, 0, 0, Q_MIN, 1'b1, 0, 0, 0, Q_MAX, 1'b1},
    // full-scale operands, checked by the predictor
    '{MODE_PRODUCT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
      1'b0, 0, 0, 0, 0, 1'b0},
    '{MODE_PRODUCT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
      1'b0, 0, 0, 0, 0, 1'b0},
    '{MODE_PRODUCT, 32'sh1234_5678, -32'sh0ABC_DEF0, 32'sh0000_8001, -32'sh0001_7FFF,
      -32'sh0003_0001, 32'sh0000_FFFF, 32'sh7654_3210, 32'sh0000_7FFF,
      1'b0, 0, 0, 0, 0, 1'b0},
    // rotation by identity returns the vector; b_w must not matter, r_w is zero
    '{MODE_ROTATE, 0, 0, 0, Q_ONE, Q_MAX, Q_MIN, -Q_LSB, 32'sh5A5A_5A5A,
      1'b1, Q_MAX, Q_MIN, -Q_LSB, 0, 1'b0},
    '{MODE_ROTATE, 0, 0, 0, Q_ONE, Q_MAX, Q_MIN, -Q_LSB, Q_MIN,
      1'b1, Q_MAX, Q_MIN, -Q_LSB, 0, 1'b0},
    // zero quaternion wipes any vector
    '{MODE_ROTATE, 0, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1, 0, 0, 0, 0, 1'b0},
    // quarter turn about z
    '{MODE_ROTATE, 0, 0, 32'sh0000_B505, 32'sh0000_B505, Q_ONE, 0, 0, 0,
      1'b0, 0, 0, 0, 0, 1'b0},
    // conjugate of the most negative component, intermediate saturation
    '{MODE_ROTATE, Q_MIN, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE, 0, 1'b0, 0, 0, 0, 0, 1'b0},
    '{MODE_ROTATE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
      1'b0, 0, 0, 0, 0, 1'b0},
    '{MODE_ROTATE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
      1'b0, 0, 0, 0, 0, 1'b0},
    '{MODE_ROTATE, Q_HALF, Q_HALF, Q_HALF, Q_HALF, Q_MAX, -Q_ONE, Q_HALF, Q_MIN,
      1'b0, 0, 0, 0, 0, 1'b0}
  };

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         out_tuser;

  quat_res_t expected_results [$];
  int        mismatch_count = 0;
  int        idle_cycles    = 0;

  quaternion_multiply_rotate_unit_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Full-width product, rounded to nearest with ties toward plus infinity
  function automatic rnd_t round_mul(op_t x, op_t y);
    prod_t p;
    p = prod_t'(x) * prod_t'(y);
    p = p + (prod_t'(1) <<< (FRAC_BITS - 1));
    return rnd_t'(p >>> FRAC_BITS);
  endfunction

  function automatic q_t clamp_q(sum_t s);
    if (s > sum_t'(Q_MAX)) return Q_MAX;
    if (s < sum_t'(Q_MIN)) return Q_MIN;
    return q_t'(s);
  endfunction

  // Hamilton product p*q; the scalar is skipped (and zeroed) unless with_w
  function automatic quat_res_t hamilton_q(op_t [3:0] p, op_t [3:0] q, logic with_w);
    sum_t      sx, sy, sz, sw;
    quat_res_t r;
    sx = sum_t'(round_mul(p[IDX_W], q[IDX_X])) + round_mul(p[IDX_X], q[IDX_W])
       + round_mul(p[IDX_Y], q[IDX_Z]) - round_mul(p[IDX_Z], q[IDX_Y]);
    sy = sum_t'(round_mul(p[IDX_W], q[IDX_Y])) - round_mul(p[IDX_X], q[IDX_Z])
       + round_mul(p[IDX_Y], q[IDX_W]) + round_mul(p[IDX_Z], q[IDX_X]);
    sz = sum_t'(round_mul(p[IDX_W], q[IDX_Z])) + round_mul(p[IDX_X], q[IDX_Y])
       - round_mul(p[IDX_Y], q[IDX_X]) + round_mul(p[IDX_Z], q[IDX_W]);
    sw = sum_t'(round_mul(p[IDX_W], q[IDX_W])) - round_mul(p[IDX_X], q[IDX_X])
       - round_mul(p[IDX_Y], q[IDX_Y]) - round_mul(p[IDX_Z], q[IDX_Z]);
    r.x = clamp_q(sx);
    r.y = clamp_q(sy);
    r.z = clamp_q(sz);
    r.ovf = (sum_t'(r.x) != sx) || (sum_t'(r.y) != sy) || (sum_t'(r.z) != sz);
    if (with_w) begin
      r.w   = clamp_q(sw);
      r.ovf = r.ovf || (sum_t'(r.w) != sw);
    end else begin
      r.w = '0;
    end
    return r;
  endfunction

  // Expected result of one operand transfer
  function automatic quat_res_t predict_quat(logic mode, opnd_t o);
    op_t [3:0] av, bv, tv, cv;
    quat_res_t t, r;
    av[IDX_X] = o.ax;
    av[IDX_Y] = o.ay;
    av[IDX_Z] = o.az;
    av[IDX_W] = o.aw;
    bv[IDX_X] = o.bx;
    bv[IDX_Y] = o.by;
    bv[IDX_Z] = o.bz;
    bv[IDX_W] = o.bw;
    if (mode == MODE_PRODUCT) return hamilton_q(av, bv, 1'b1);
    // rotate: T = A*(v,0), then T*conj(A) with the conjugate exact at 33 bits
    bv[IDX_W] = '0;
    t = hamilton_q(av, bv, 1'b1);
    tv[IDX_X] = t.x;
    tv[IDX_Y] = t.y;
    tv[IDX_Z] = t.z;
    tv[IDX_W] = t.w;
    cv[IDX_X] = -av[IDX_X];
    cv[IDX_Y] = -av[IDX_Y];
    cv[IDX_Z] = -av[IDX_Z];
    cv[IDX_W] = av[IDX_W];
    r = hamilton_q(tv, cv, 1'b0);
    r.ovf = r.ovf || t.ovf;
    return r;
  endfunction

  // Unit-scale values most often, plus shifted, full-range and corner values
  function automatic q_t rand_comp();
    q_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = q_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      4, 5: begin
        v = $urandom;
        v = v >>> $urandom_range(4, 20);
      end
      6, 7: v = $urandom;
      default: begin
        case ($urandom_range(0, 7))
          0: v = Q_MIN;
          1: v = Q_MAX;
          2: v = '0;
          3: v = Q_LSB;
          4: v = -Q_LSB;
          5: v = Q_ONE;
          6: v = -Q_ONE;
          default: v = Q_HALF;
        endcase
      end
    endcase
    return v;
  endfunction

  // Present one operand transfer after gap idle cycles; queue its result on acceptance
  task automatic send_quat(logic mode, opnd_t ops, quat_res_t want, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= ops;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(want);
    @(negedge clk);
  endtask

  // Hold the sender idle until every queued result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  // Stimulus: reset, directed table, random operands
  initial begin
    opnd_t     ops;
    quat_res_t want;
    stim_row_t row;
    logic      mode;
    int        gap;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= MODE_PRODUCT;
    in_tdata  <= '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row    = DIRECTED[i];
      ops.ax = row.ax;
      ops.ay = row.ay;
      ops.az = row.az;
      ops.aw = row.aw;
      ops.bx = row.bx;
      ops.by = row.by;
      ops.bz = row.bz;
      ops.bw = row.bw;
      if (row.known) begin
        want.x   = row.rx;
        want.y   = row.ry;
        want.z   = row.rz;
        want.w   = row.rw;
        want.ovf = row.ovf;
      end else begin
        want = predict_quat(row.mode, ops);
      end
      send_quat(row.mode, ops, want, $urandom_range(0, 5));
    end
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // pause once more halfway so the pipeline empties under traffic
      if (n == RANDOM_ITEMS / 2) wait_drained();
      mode   = 1'($urandom_range(0, 1));
      ops.ax = rand_comp();
      ops.ay = rand_comp();
      ops.az = rand_comp();
      ops.aw = rand_comp();
      ops.bx = rand_comp();
      ops.by = rand_comp();
      ops.bz = rand_comp();
      ops.bw = rand_comp();
      // every third block of 40 items goes back to back
      gap = (((n / 40) % 3) == 2) ? 0 : $urandom_range(0, 5);
      send_quat(mode, ops, predict_quat(mode, ops), gap);
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random back-pressure, compare each transfer with the oldest expectation
  initial begin
    quat_res_t want;
    vec_t      got;
    int        stall;
    int        seen;
    out_tready <= 1'b0;
    seen = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      // every third block of 35 results is taken without stalls
      stall = (((seen / 35) % 3) == 1) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = out_tdata;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: x=%h y=%h z=%h w=%h ovf=%b",
                   got.x, got.y, got.z, got.w, out_tuser);
      end else begin
        want = expected_results.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.w !== want.w || out_tuser !== want.ovf) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: want x=%h y=%h z=%h w=%h ovf=%b / got x=%h y=%h z=%h w=%h ovf=%b",
                     want.x, want.y, want.z, want.w, want.ovf,
                     got.x, got.y, got.z, got.w, out_tuser);
        end
      end
      seen++;
      @(negedge clk);
    end
  end

  // Watchdog: drop the run when no transfer happens on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/core/qmr_pkg.sv
rtl/core/qmr_hamilton.sv
rtl/core/quaternion_multiply_rotate_unit_top.sv
dv/testbench.sv
